/* hdl/psekm_pkg.sv */
// shared types and constants for the per-source ewma kill monitor
// no dependencies

package psekm_pkg;

   localparam int unsigned GAIN_W = 16;
   localparam int unsigned LEAK_W = 25;
   localparam int unsigned LAT_W = 45;
   localparam int unsigned EDGE_W = 24;
   localparam int unsigned LATENCY_W = 20;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned FRAC_W = 17;
   localparam int unsigned MIN_TRADES = 5;

   localparam logic [1:0] OP_SUBMIT = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [1:0] CSR_GAIN = 2'd0;
   localparam logic [1:0] CSR_LEAK = 2'd1;
   localparam logic [1:0] CSR_LAT = 2'd2;

   // one shared multiply request: signed a times signed b
   typedef struct packed {
      logic              start;
      logic signed [46:0] a;
      logic signed [20:0] b;
   } mul_req_type;

endpackage

/* hdl/psekm_mul.sv */
// shift-add multiplier, two bits of the multiplier a cycle, 47 x 21 signed
// depends on psekm_pkg

module psekm_mul
   import psekm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mul_req_type        req,
   output logic               done,
   output logic signed [67:0] product
);

   logic signed [67:0] acc_ff, acc_in;
   logic signed [67:0] mcand_ff, mcand_in;
   logic [20:0]        mplier_ff, mplier_in;
   logic [3:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [67:0] part;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      part = '0;
      if (req.start) begin
         acc_in = '0;
         mcand_in = 68'(req.a);
         mplier_in = req.b;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) part = mcand_ff;
         if (mplier_ff[1]) part = part + (mcand_ff <<< 1);
         // bit 20 is the sign bit and weighs negative
         if (step_ff == 4'd10) begin
            part = mplier_ff[0] ? -mcand_ff : '0;
         end
         acc_in = acc_ff + part;
         mcand_in = mcand_ff <<< 2;
         mplier_in = mplier_ff >> 2;
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

/* hdl/per_source_ewma_kill_monitor.sv */
// top level of the per-source ewma kill monitor: slot table, engine stats,
// sequencer; depends on psekm_pkg and psekm_mul
//
// usage: one request transfer on req_* gives exactly one response on rsp_*.
// submit and cancel pass through idle, table read and write, decision
// and response. a fill also runs three multiplies on the shared
// two-bit-a-cycle multiplier (latency times leak, then the two average
// updates) and a restoring division for the win rate, besides table
// read, decision, writeback, response and idle.
// req_ready is low while an item is at work or while its response waits;
// a stalled receiver holds rsp_valid and the payload.
// the slot memory has no per-entry reset: after reset a clearing pass of
// all ORDER_SLOTS entries zeroes the valid bits while req_ready stays low;
// csr writes are taken at any time and should be made only while idle.
// engine stats are flip-flops cleared at reset. csr index 0 is the gain,
// 1 the leak limit, 2 the latency limit; other indexes are ignored.

module per_source_ewma_kill_monitor
   import psekm_pkg::*;
#(
   parameter int ORDER_SLOTS = 256,
   parameter int ENGINE_COUNT = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic [7:0]               req_order_slot,
   input  logic [3:0]               req_engine,
   input  logic signed [23:0]       req_predicted_edge,
   input  logic signed [23:0]       req_realized_pnl,
   input  logic [19:0]              req_latency,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_matched,
   output logic                     rsp_killed,
   output logic [3:0]               rsp_engine_out,
   output logic signed [24:0]       rsp_leak_avg,
   output logic signed [44:0]       rsp_latency_avg,
   output logic [16:0]              rsp_win_fraction,
   output logic [31:0]              rsp_trade_count,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [63:0]              csr_data
);

   localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
   localparam int EW = (ENGINE_COUNT > 1) ? $clog2(ENGINE_COUNT) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_FACTOR, ST_LEAKAVG, ST_LATAVG,
      ST_DIV, ST_KILL, ST_RESP
   } state_type;

   state_type state_ff;

   // config
   logic [15:0]        gain_ff;
   logic signed [24:0] leak_lim_ff;
   logic signed [44:0] lat_lim_ff;

   // slot memory
   logic [EW+EDGE_W:0] slot_mem [ORDER_SLOTS];
   logic [EW+EDGE_W:0] rd_ff;
   logic [SW:0]        clr_ff;

   // engine stats
   logic signed [24:0] leak_e_ff [ENGINE_COUNT];
   logic signed [44:0] lat_e_ff [ENGINE_COUNT];
   logic [31:0]        win_e_ff [ENGINE_COUNT];
   logic [31:0]        cnt_e_ff [ENGINE_COUNT];

   // item
   logic [1:0]         op_ff;
   logic [SW-1:0]      slot_ff;
   logic [EW-1:0]      eng_ff;
   logic signed [23:0] pred_ff;
   logic signed [23:0] real_ff;
   logic [19:0]        lat_ff;
   logic [EW-1:0]      fe_ff;
   logic signed [25:0] leak_ff;
   logic signed [44:0] factor_ff;
   logic signed [24:0] nleak_ff;
   logic signed [44:0] nlat_ff;
   logic [31:0]        ncnt_ff;
   logic [31:0]        nwin_ff;
   logic               phase_ff;

   // divider
   logic [47:0]        rem_ff;
   logic [48:0]        quo_ff;
   logic [5:0]         dstep_ff;

   mul_req_type        mreq;
   logic               mdone;
   logic signed [67:0] mprod;

   psekm_mul u_mul (
      .clock(clock), .reset(reset), .req(mreq), .done(mdone), .product(mprod)
   );

   logic [SW-1:0] req_slot;
   assign req_slot = SW'(req_order_slot % ORDER_SLOTS);

   function automatic logic signed [67:0] floor16(input logic signed [67:0] p);
      return p >>> 16;
   endfunction

   logic signed [67:0] upd;
   logic [48:0]        trial;
   logic [47:0]        rem_sh;
   logic               rd_v;
   logic [EW-1:0]      rd_eng;
   logic signed [23:0] rd_pred;

   assign rd_v = rd_ff[EW+EDGE_W];
   assign rd_eng = rd_ff[EW+EDGE_W-1:EDGE_W];
   assign rd_pred = rd_ff[EDGE_W-1:0];
   assign rem_sh = {rem_ff[46:0], quo_ff[48]};
   assign trial = {1'b0, rem_sh} - {17'd0, ncnt_ff};
   assign upd = phase_ff ? (68'(nlat_ff) + floor16(mprod))
                         : (68'(nleak_ff) + floor16(mprod));

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      mreq = '0;
      if (state_ff == ST_DECIDE && op_ff == OP_FILL && rd_v) begin
         mreq.start = 1'b1;
         mreq.a = 47'(leak_ff);
         mreq.b = 21'($signed({1'b0, lat_ff}));
      end else if (state_ff == ST_FACTOR && mdone) begin
         mreq.start = 1'b1;
         mreq.a = 47'(leak_ff) - 47'(leak_e_ff[fe_ff]);
         mreq.b = 21'($signed({1'b0, gain_ff}));
      end else if (state_ff == ST_LEAKAVG && mdone) begin
         mreq.start = 1'b1;
         mreq.a = 47'(factor_ff) - 47'(lat_e_ff[fe_ff]);
         mreq.b = 21'($signed({1'b0, gain_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         gain_ff <= 16'd6554;
         leak_lim_ff <= 25'sd1280;
         lat_lim_ff <= 45'sd1310720;
         for (int i = 0; i < ENGINE_COUNT; i++) begin
            leak_e_ff[i] <= '0;
            lat_e_ff[i] <= '0;
            win_e_ff[i] <= '0;
            cnt_e_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN: gain_ff <= csr_data[15:0];
               CSR_LEAK: leak_lim_ff <= csr_data[24:0];
               CSR_LAT:  lat_lim_ff <= csr_data[44:0];
               default: ;
            endcase
         end
         if (state_ff == ST_CLEAR) slot_mem[clr_ff[SW-1:0]] <= '0;
         if (state_ff == ST_IDLE) rd_ff <= slot_mem[req_slot];
         if (state_ff == ST_READ) begin
            if (op_ff == OP_SUBMIT)
               slot_mem[slot_ff] <= {1'b1, eng_ff, pred_ff};
            else if (op_ff == OP_CANCEL || (op_ff == OP_FILL && rd_v))
               slot_mem[slot_ff] <= {1'b0, rd_eng, rd_pred};
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (SW+1)'(ORDER_SLOTS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_operation;
                  slot_ff <= req_slot;
                  eng_ff <= EW'(req_engine % ENGINE_COUNT);
                  pred_ff <= req_predicted_edge;
                  real_ff <= req_realized_pnl;
                  lat_ff <= req_latency;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               fe_ff <= EW'(rd_eng % ENGINE_COUNT);
               leak_ff <= 26'(rd_pred) - 26'(real_ff);
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               rsp_matched <= rd_v;
               rsp_killed <= 1'b0;
               rsp_engine_out <= '0;
               rsp_leak_avg <= '0;
               rsp_latency_avg <= '0;
               rsp_win_fraction <= '0;
               rsp_trade_count <= '0;
               if (op_ff == OP_FILL && rd_v) state_ff <= ST_FACTOR;
               else state_ff <= ST_RESP;
            end
            ST_FACTOR: begin
               phase_ff <= 1'b0;
               nleak_ff <= leak_e_ff[fe_ff];
               nlat_ff <= lat_e_ff[fe_ff];
               if (mdone) begin
                  factor_ff <= mprod[44:0];
                  state_ff <= ST_LEAKAVG;
               end
            end
            ST_LEAKAVG: begin
               if (mdone) begin
                  nleak_ff <= upd[24:0];
                  phase_ff <= 1'b1;
                  state_ff <= ST_LATAVG;
               end
            end
            ST_LATAVG: begin
               // a saturated trade count freezes both counts
               if (cnt_e_ff[fe_ff] != 32'hFFFF_FFFF) begin
                  ncnt_ff <= cnt_e_ff[fe_ff] + 32'd1;
                  nwin_ff <= (real_ff > 0) ? win_e_ff[fe_ff] + 32'd1 : win_e_ff[fe_ff];
               end else begin
                  ncnt_ff <= cnt_e_ff[fe_ff];
                  nwin_ff <= win_e_ff[fe_ff];
               end
               if (mdone) begin
                  nlat_ff <= upd[44:0];
                  state_ff <= ST_DIV;
                  rem_ff <= '0;
                  dstep_ff <= '0;
               end
            end
            ST_DIV: begin
               if (dstep_ff == 6'd0) begin
                  quo_ff <= {1'b0, nwin_ff, 16'd0};
                  dstep_ff <= 6'd1;
               end else begin
                  if (!trial[48]) begin
                     rem_ff <= trial[47:0];
                     quo_ff <= {quo_ff[47:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[47:0], 1'b0};
                  end
                  dstep_ff <= dstep_ff + 6'd1;
                  if (dstep_ff == 6'd49) state_ff <= ST_KILL;
               end
            end
            ST_KILL: begin
               leak_e_ff[fe_ff] <= nleak_ff;
               lat_e_ff[fe_ff] <= nlat_ff;
               cnt_e_ff[fe_ff] <= ncnt_ff;
               win_e_ff[fe_ff] <= nwin_ff;
               rsp_killed <= (ncnt_ff >= MIN_TRADES) &&
                             (nleak_ff > leak_lim_ff || nlat_ff > lat_lim_ff);
               rsp_engine_out <= 4'(fe_ff);
               rsp_leak_avg <= nleak_ff;
               rsp_latency_avg <= nlat_ff;
               rsp_win_fraction <= quo_ff[16:0];
               rsp_trade_count <= ncnt_ff;
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = (state_ff == ST_RESP);

endmodule
